// File: rtl/hec_pkg.sv
// hec_pkg: shared types, constants and helper functions for the hall edge
// encoder capture block. No dependencies.
`default_nettype none

package hec_pkg;

  localparam int COUNT_BITS = 16;
  localparam int ENC_BITS   = 32;
  localparam int NUM_SENS   = 3;
  localparam int OUT_CNT_W  = 16;
  localparam int POS_W      = 32;

  // op codes
  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_SNAP = 2'd2;

  // sensor codes
  localparam logic [1:0] SENS_FRONT = 2'd0;
  localparam logic [1:0] SENS_CALIB = 2'd1;
  localparam logic [1:0] SENS_BACK  = 2'd2;

  localparam logic signed [ENC_BITS-1:0] ENC_MIN = {1'b1, {(ENC_BITS-1){1'b0}}};
  localparam logic signed [ENC_BITS-1:0] ENC_MAX = {1'b0, {(ENC_BITS-1){1'b1}}};

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         sensor;
    logic               hall_level;
    logic signed [31:0] encoder_count;
  } in_item_t;

  typedef struct packed {
    logic               front_level;
    logic [15:0]        front_rise_count;
    logic [15:0]        front_fall_count;
    logic               calib_level;
    logic [15:0]        calib_rise_count;
    logic [15:0]        calib_fall_count;
    logic               back_level;
    logic [15:0]        back_rise_count;
    logic [15:0]        back_fall_count;
    logic signed [31:0] position;
    logic signed [31:0] rise_position;
    logic signed [31:0] fall_position;
  } out_item_t;

  // per-sensor command from the top level
  typedef struct packed {
    logic                edge_en;
    logic                poll_en;
    logic                snap_en;
    logic                level;
    logic [ENC_BITS-1:0] enc;
  } sens_cmd_t;

  // per-sensor status toward the report stage
  typedef struct packed {
    logic                  polled;
    logic [COUNT_BITS-1:0] rise_cnt;
    logic [COUNT_BITS-1:0] fall_cnt;
    logic [ENC_BITS-1:0]   rise_latch;
    logic [ENC_BITS-1:0]   fall_latch;
    logic                  rise_chg;
    logic                  fall_chg;
  } sens_stat_t;

  // sign-interpret, optionally negate, clamp to the symmetric range
  function automatic logic signed [POS_W-1:0] report_pos(
    input logic [ENC_BITS-1:0] raw,
    input logic                rev
  );
    logic signed [ENC_BITS-1:0] v;
    logic signed [ENC_BITS-1:0] r;
    v = signed'(raw);
    if (v == ENC_MIN) begin
      r = rev ? ENC_MAX : -ENC_MAX;
    end else begin
      r = rev ? -v : v;
    end
    return POS_W'(r);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
    return OUT_CNT_W'(c);
  endfunction

endpackage

`default_nettype wire

// File: rtl/hall_edge_encoder_capture.sv
// hall_edge_encoder_capture: top level, input register, per-sensor trackers
// and report stage. Depends on hec_pkg, hec_sensor and hec_report.
`default_nettype none

// Usage
//   in_*  : one beat per event. op selects edge event, poll sample or
//           snapshot request; sensor picks front, calibration or back.
//   out_* : one beat per snapshot request, carrying polled levels, edge
//           counts, the snapshot position and the reported edge positions.
//   cfg_* : writes the reversed bit; always ready, write only while idle.
// Timing
//   a beat lands in the input register, then the sensor state and, for a
//   snapshot, the result register are updated as it leaves that register:
//   a snapshot result is valid once the result register is loaded and
//   stays there until it is taken.
//   one beat per cycle is taken; an edge or poll beat in the input register
//   never waits, the only stall is a snapshot sitting in the input register
//   while the result register still holds an untaken result.
// Reset
//   synchronous, active low: levels and counters to zero, debounce flags
//   set, held edge positions zero, reversed cleared, no result pending.
// Backpressure
//   while out_ready is low the result stays put; edge and poll beats still
//   flow, and in_ready drops only once a second snapshot is waiting.
// Illegal op or sensor codes are taken and have no effect.
module hall_edge_encoder_capture
  import hec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  // input register
  logic       in_valid_r;
  in_item_t   in_data_r;
  logic       reversed_r;

  logic       slot_free;
  logic       is_snap;
  logic       advance;

  sens_cmd_t  [NUM_SENS-1:0] cmd;
  sens_stat_t [NUM_SENS-1:0] stat;

  // edge and poll beats retire at once, a snapshot needs the result slot
  assign is_snap  = in_data_r.op == OP_SNAP;
  assign advance  = in_valid_r && (!is_snap || slot_free);
  assign in_ready = !in_valid_r || advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      reversed_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (cfg_valid) begin
        reversed_r <= cfg_data;
      end
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // one tracker per sensor; an unknown sensor code addresses none
  for (genvar i = 0; i < NUM_SENS; i++) begin : g_sens
    always_comb begin
      cmd[i].edge_en = advance && (in_data_r.op == OP_EDGE) &&
                       (in_data_r.sensor == 2'(i));
      cmd[i].poll_en = advance && (in_data_r.op == OP_POLL) &&
                       (in_data_r.sensor == 2'(i));
      cmd[i].snap_en = advance && is_snap;
      cmd[i].level   = in_data_r.hall_level;
      cmd[i].enc     = in_data_r.encoder_count[ENC_BITS-1:0];
    end

    hec_sensor u_sensor (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[i]),
      .stat  (stat[i])
    );
  end

  // result register and held edge positions
  hec_report u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && is_snap),
    .reversed  (reversed_r),
    .enc       (in_data_r.encoder_count[ENC_BITS-1:0]),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .slot_free (slot_free)
  );

endmodule

`default_nettype wire

// File: rtl/hec_sensor.sv
// hec_sensor: level tracking, poll debounce, edge counters and edge latches
// for one hall sensor. Depends on hec_pkg.
`default_nettype none

module hec_sensor
  import hec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sens_cmd_t  cmd,
  output sens_stat_t      stat
);

  logic                  trk_r;
  logic                  flag_r;
  logic                  polled_r;
  logic [COUNT_BITS-1:0] rise_cnt_r;
  logic [COUNT_BITS-1:0] fall_cnt_r;
  logic [COUNT_BITS-1:0] prev_rise_r;
  logic [COUNT_BITS-1:0] prev_fall_r;
  logic [ENC_BITS-1:0]   rise_latch_r;
  logic [ENC_BITS-1:0]   fall_latch_r;
  logic                  mm;

  assign mm = cmd.level != trk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r        <= 1'b0;
      flag_r       <= 1'b1;
      polled_r     <= 1'b0;
      rise_cnt_r   <= '0;
      fall_cnt_r   <= '0;
      prev_rise_r  <= '0;
      prev_fall_r  <= '0;
      rise_latch_r <= '0;
      fall_latch_r <= '0;
    end else begin
      if (cmd.edge_en) begin
        if (mm && cmd.level) begin
          rise_cnt_r   <= rise_cnt_r + 1'b1;
          rise_latch_r <= cmd.enc;
        end else if (mm) begin
          fall_cnt_r   <= fall_cnt_r + 1'b1;
          fall_latch_r <= cmd.enc;
        end
        trk_r <= cmd.level;
      end
      if (cmd.poll_en) begin
        polled_r <= cmd.level;
        // second poll mismatch in a row (or the first after reset) forces the tracked level
        if (mm && flag_r) begin
          trk_r  <= cmd.level;
          flag_r <= 1'b0;
        end else begin
          flag_r <= mm;
        end
      end
      if (cmd.snap_en) begin
        prev_rise_r <= rise_cnt_r;
        prev_fall_r <= fall_cnt_r;
      end
    end
  end

  always_comb begin
    stat.polled     = polled_r;
    stat.rise_cnt   = rise_cnt_r;
    stat.fall_cnt   = fall_cnt_r;
    stat.rise_latch = rise_latch_r;
    stat.fall_latch = fall_latch_r;
    stat.rise_chg   = rise_cnt_r != prev_rise_r;
    stat.fall_chg   = fall_cnt_r != prev_fall_r;
  end

endmodule

`default_nettype wire

// File: rtl/hec_report.sv
// hec_report: snapshot result register, held edge positions and the
// calibration/back/front priority select. Depends on hec_pkg.
`default_nettype none

module hec_report
  import hec_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic                          reversed,
  input  wire logic [ENC_BITS-1:0]           enc,
  input  wire sens_stat_t [NUM_SENS-1:0]     stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output out_item_t                          out_data,
  output logic                               slot_free
);

  logic                    valid_r;
  out_item_t               data_r;
  logic signed [POS_W-1:0] held_rise_r;
  logic signed [POS_W-1:0] held_fall_r;
  logic signed [POS_W-1:0] held_rise_nxt;
  logic signed [POS_W-1:0] held_fall_nxt;
  logic [ENC_BITS-1:0]     rise_src;
  logic [ENC_BITS-1:0]     fall_src;

  assign slot_free = !valid_r || out_ready;

  // calibration wins over back, back over front
  always_comb begin
    rise_src      = stat[SENS_FRONT].rise_latch;
    held_rise_nxt = held_rise_r;
    if (stat[SENS_CALIB].rise_chg) begin
      rise_src = stat[SENS_CALIB].rise_latch;
    end else if (stat[SENS_BACK].rise_chg) begin
      rise_src = stat[SENS_BACK].rise_latch;
    end
    if (stat[SENS_CALIB].rise_chg || stat[SENS_BACK].rise_chg ||
        stat[SENS_FRONT].rise_chg) begin
      held_rise_nxt = report_pos(rise_src, reversed);
    end

    fall_src      = stat[SENS_FRONT].fall_latch;
    held_fall_nxt = held_fall_r;
    if (stat[SENS_CALIB].fall_chg) begin
      fall_src = stat[SENS_CALIB].fall_latch;
    end else if (stat[SENS_BACK].fall_chg) begin
      fall_src = stat[SENS_BACK].fall_latch;
    end
    if (stat[SENS_CALIB].fall_chg || stat[SENS_BACK].fall_chg ||
        stat[SENS_FRONT].fall_chg) begin
      held_fall_nxt = report_pos(fall_src, reversed);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      held_rise_r <= '0;
      held_fall_r <= '0;
    end else begin
      if (load) begin
        valid_r     <= 1'b1;
        held_rise_r <= held_rise_nxt;
        held_fall_r <= held_fall_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r.front_level      <= stat[SENS_FRONT].polled;
      data_r.front_rise_count <= cnt_out(stat[SENS_FRONT].rise_cnt);
      data_r.front_fall_count <= cnt_out(stat[SENS_FRONT].fall_cnt);
      data_r.calib_level      <= stat[SENS_CALIB].polled;
      data_r.calib_rise_count <= cnt_out(stat[SENS_CALIB].rise_cnt);
      data_r.calib_fall_count <= cnt_out(stat[SENS_CALIB].fall_cnt);
      data_r.back_level       <= stat[SENS_BACK].polled;
      data_r.back_rise_count  <= cnt_out(stat[SENS_BACK].rise_cnt);
      data_r.back_fall_count  <= cnt_out(stat[SENS_BACK].fall_cnt);
      data_r.position         <= report_pos(enc, reversed);
      data_r.rise_position    <= held_rise_nxt;
      data_r.fall_position    <= held_fall_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// File: rtl/hec_checker.sv
// hec_checker: port-level assertions for hall_edge_encoder_capture, bound to
// the top level. Depends on hec_pkg.
`default_nettype none

module hec_checker
  import hec_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data,
  input wire logic      cfg_valid,
  input wire logic      cfg_ready
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without result backpressure");

  // a fresh result comes from a snapshot beat taken into the input register, then loaded
  a_result_src: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $past(rst_n, 2) && $rose(out_valid) |->
      $past(in_valid && in_ready && in_data.op == OP_SNAP, 2))
    else $error("result without snapshot request");

  // config port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind hall_edge_encoder_capture hec_checker u_hec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
